[hdl/fys_pkg.sv]
// ----------------------------------------------------------------------------
// Shuffle engine package
// Sizes, register map, sequencer states and the command structs shared by
// the store, the remainder unit and the top level.
// ----------------------------------------------------------------------------
package fys_pkg;

   // list capacity and derived widths
   localparam int MAX_ITEMS = 32;
   localparam int IDX_W     = $clog2(MAX_ITEMS);
   localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

   // field widths
   localparam int VAL_W  = 8;
   localparam int RND_W  = 8;
   localparam int MODE_W = 1;
   localparam int PCNT_W = 7;
   localparam int STEP_W = $clog2(RND_W);

   // register port
   localparam int REG_IDX_W = 1;
   localparam int ADDR_W    = REG_IDX_W + 2;
   localparam int CSR_W     = 32;

   localparam logic [REG_IDX_W-1:0] REG_SHUFFLE_MODE  = 1'b0;
   localparam logic [REG_IDX_W-1:0] REG_PARTIAL_COUNT = 1'b1;

   // shuffle modes
   localparam logic [MODE_W-1:0] MODE_FULL    = 1'b0;
   localparam logic [MODE_W-1:0] MODE_PARTIAL = 1'b1;

   // sequencer states
   typedef enum logic [3:0] {
      ST_LOAD,
      ST_SETUP,
      ST_MOD_START,
      ST_MOD_WAIT,
      ST_RD_J,
      ST_WR_I,
      ST_WR_J,
      ST_OUT_RD,
      ST_OUT_LD
   } fys_state_type;

   // one store port: a write and a registered read per cycle
   typedef struct packed {
      logic             we;
      logic [IDX_W-1:0] waddr;
      logic [VAL_W-1:0] wdata;
      logic             re;
      logic [IDX_W-1:0] raddr;
   } fys_mem_cmd_type;

   // remainder unit request and status
   typedef struct packed {
      logic             start;
      logic [RND_W-1:0] dividend;
      logic [CNT_W-1:0] divisor;
   } fys_div_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [CNT_W-1:0] remainder;
   } fys_div_rsp_type;

endpackage

[hdl/fys_store.sv]
// ----------------------------------------------------------------------------
// Shuffle engine list store
// Element memory and random byte memory, one write and one registered read
// port each.
// ----------------------------------------------------------------------------
module fys_store (
   input  logic                          clock,
   input  fys_pkg::fys_mem_cmd_type      elem_cmd,
   input  fys_pkg::fys_mem_cmd_type      rand_cmd,
   output logic [fys_pkg::VAL_W-1:0]     elem_rdata,
   output logic [fys_pkg::VAL_W-1:0]     rand_rdata
);

   logic [fys_pkg::VAL_W-1:0] elem_mem [fys_pkg::MAX_ITEMS];
   logic [fys_pkg::VAL_W-1:0] rand_mem [fys_pkg::MAX_ITEMS];
   logic [fys_pkg::VAL_W-1:0] elem_rdata_ff;
   logic [fys_pkg::VAL_W-1:0] rand_rdata_ff;

   // element memory
   always_ff @(posedge clock) begin
      if (elem_cmd.we) begin
         elem_mem[elem_cmd.waddr] <= elem_cmd.wdata;
      end
      if (elem_cmd.re) begin
         elem_rdata_ff <= elem_mem[elem_cmd.raddr];
      end
   end

   // random byte memory
   always_ff @(posedge clock) begin
      if (rand_cmd.we) begin
         rand_mem[rand_cmd.waddr] <= rand_cmd.wdata;
      end
      if (rand_cmd.re) begin
         rand_rdata_ff <= rand_mem[rand_cmd.raddr];
      end
   end

   assign elem_rdata = elem_rdata_ff;
   assign rand_rdata = rand_rdata_ff;

endmodule

[hdl/fys_rem_unit.sv]
// ----------------------------------------------------------------------------
// Shuffle engine remainder unit
// Bit-serial restoring division of the random byte by a list span; one
// dividend bit per cycle, remainder only.
// ----------------------------------------------------------------------------
module fys_rem_unit (
   input  logic                     clock,
   input  logic                     reset,
   input  fys_pkg::fys_div_req_type div_req,
   output fys_pkg::fys_div_rsp_type div_rsp
);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [fys_pkg::STEP_W-1:0]  step_ff, step_in;
   logic [fys_pkg::RND_W-1:0]   dvd_ff, dvd_in;
   logic [fys_pkg::CNT_W-1:0]   dsr_ff, dsr_in;
   logic [fys_pkg::CNT_W-1:0]   rem_ff, rem_in;
   logic [fys_pkg::CNT_W:0]     trial;
   logic [fys_pkg::CNT_W:0]     diff;
   logic                        fits;

   // shift in the next dividend bit and try the subtract
   assign trial = {rem_ff, dvd_ff[fys_pkg::RND_W-1]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign fits  = (trial >= {1'b0, dsr_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         step_in = '0;
         dvd_in  = div_req.dividend;
         dsr_in  = div_req.divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         dvd_in  = {dvd_ff[fys_pkg::RND_W-2:0], 1'b0};
         rem_in  = fits ? diff[fys_pkg::CNT_W-1:0] : trial[fys_pkg::CNT_W-1:0];
         step_in = step_ff + fys_pkg::STEP_W'(1);
         if (step_ff == fys_pkg::STEP_W'(fys_pkg::RND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   // operands need no reset
   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
   end

   assign div_rsp.busy      = busy_ff;
   assign div_rsp.done      = done_ff;
   assign div_rsp.remainder = rem_ff;

`ifndef SYNTH
   // a new division never starts over a running one or with a zero divisor
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> (!busy_ff && div_req.divisor != '0))
      else $error("remainder unit started while busy or with zero divisor");

   // the remainder handed back is below the divisor
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (rem_ff < dsr_ff))
      else $error("remainder not below divisor");
`endif

endmodule

[hdl/fisher_yates_shuffle_engine.sv]
// ----------------------------------------------------------------------------
// Fisher-Yates shuffle engine
// Loads a list of bytes with one random byte each, permutes it in place
// with a full or a partial shuffle and streams the permuted list out.
//
//   channel  dir  handshake          payload
//   req_     in   tvalid/tready      tdata[7:0] element, [15:8] random; tlast
//   rsp_     out  tvalid/tready      tdata[7:0] element; tlast on final word
//   csr_     in   psel/penable       mode at 0x0, partial count at 0x4
//
// Loading takes one word per cycle until tlast. After a setup state the
// shuffle runs one swap after another: each has a start state, a wait on the
// bit-serial remainder unit and the read-read-write-write swap on the one
// element port; n-1 swaps in full mode and min(k,n) in partial mode, none
// for lists under two words. Output reads each word through the element
// read port, then loads it into the output register.
// Synchronous reset empties the list; memories are not cleared. Output
// stalls hold the sequencer; req_tready is high only while loading.
// ----------------------------------------------------------------------------
module fisher_yates_shuffle_engine (
   input  logic                      clock,
   input  logic                      reset,
   // input words
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [15:0]               req_tdata,   // [7:0] element_value, [15:8] rand_byte
   input  logic                      req_tlast,
   // result words
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [7:0]                rsp_tdata,   // [7:0] out_value
   output logic                      rsp_tlast,
   // register port
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [fys_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [fys_pkg::CSR_W-1:0] csr_pwdata,
   output logic [fys_pkg::CSR_W-1:0] csr_prdata,
   output logic                      csr_pready
);

   fys_pkg::fys_state_type          state_ff, state_in;
   logic [fys_pkg::CNT_W-1:0]       cnt_ff, cnt_in;
   logic [fys_pkg::CNT_W-1:0]       k_ff, k_in;
   logic [fys_pkg::IDX_W-1:0]       i_ff, i_in;
   logic [fys_pkg::IDX_W-1:0]       j_ff, j_in;
   logic [fys_pkg::IDX_W-1:0]       m_ff, m_in;
   logic [fys_pkg::IDX_W-1:0]       p_ff, p_in;
   logic [fys_pkg::VAL_W-1:0]       vi_ff, vi_in;
   logic [fys_pkg::MODE_W-1:0]      mode_ff;
   logic [fys_pkg::PCNT_W-1:0]      pcnt_ff;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [fys_pkg::VAL_W-1:0]       rsp_data_ff, rsp_data_in;
   logic                            rsp_last_ff, rsp_last_in;

   fys_pkg::fys_mem_cmd_type        elem_cmd;
   fys_pkg::fys_mem_cmd_type        rand_cmd;
   logic [fys_pkg::VAL_W-1:0]       elem_rdata;
   logic [fys_pkg::VAL_W-1:0]       rand_rdata;
   fys_pkg::fys_div_req_type        div_req;
   fys_pkg::fys_div_rsp_type        div_rsp;

   logic                            req_fire;
   logic                            csr_wr;
   logic                            full_mode;
   logic [fys_pkg::CNT_W-1:0]       k_calc;
   logic                            last_step;
   logic                            rsp_free;

   fys_store u_store (
      .clock      (clock),
      .elem_cmd   (elem_cmd),
      .rand_cmd   (rand_cmd),
      .elem_rdata (elem_rdata),
      .rand_rdata (rand_rdata)
   );

   fys_rem_unit u_rem (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // register port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= fys_pkg::MODE_FULL;
         pcnt_ff <= '0;
      end else if (csr_wr) begin
         case (csr_paddr[fys_pkg::ADDR_W-1:2])
            fys_pkg::REG_SHUFFLE_MODE: begin
               mode_ff <= csr_pwdata[fys_pkg::MODE_W-1:0];
            end
            fys_pkg::REG_PARTIAL_COUNT: begin
               pcnt_ff <= csr_pwdata[fys_pkg::PCNT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[fys_pkg::ADDR_W-1:2])
         fys_pkg::REG_SHUFFLE_MODE:  csr_prdata = fys_pkg::CSR_W'(mode_ff);
         fys_pkg::REG_PARTIAL_COUNT: csr_prdata = fys_pkg::CSR_W'(pcnt_ff);
         default:                    csr_prdata = '0;
      endcase
   end

   // shared decode
   assign req_tready = (state_ff == fys_pkg::ST_LOAD);
   assign req_fire   = req_tvalid & req_tready;
   assign full_mode  = (mode_ff == fys_pkg::MODE_FULL);
   assign k_calc     = (pcnt_ff > fys_pkg::PCNT_W'(cnt_ff)) ? cnt_ff
                                                            : fys_pkg::CNT_W'(pcnt_ff);
   assign last_step  = full_mode ? (i_ff == fys_pkg::IDX_W'(1))
                                 : ((fys_pkg::CNT_W'(i_ff) + fys_pkg::CNT_W'(1)) == k_ff);
   assign rsp_free   = ~rsp_valid_ff | rsp_tready;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      k_in         = k_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      m_in         = m_ff;
      p_in         = p_ff;
      vi_in        = vi_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      elem_cmd     = '0;
      rand_cmd     = '0;
      div_req      = '0;

      case (state_ff)
         // store words; drop them once the list is full
         fys_pkg::ST_LOAD: begin
            if (req_fire) begin
               if (cnt_ff < fys_pkg::CNT_W'(fys_pkg::MAX_ITEMS)) begin
                  elem_cmd.we    = 1'b1;
                  elem_cmd.waddr = fys_pkg::IDX_W'(cnt_ff);
                  elem_cmd.wdata = req_tdata[fys_pkg::VAL_W-1:0];
                  rand_cmd.we    = 1'b1;
                  rand_cmd.waddr = fys_pkg::IDX_W'(cnt_ff);
                  rand_cmd.wdata = req_tdata[fys_pkg::VAL_W +: fys_pkg::RND_W];
                  cnt_in         = cnt_ff + fys_pkg::CNT_W'(1);
               end
               if (req_tlast) begin
                  state_in = fys_pkg::ST_SETUP;
               end
            end
         end

         // pick the first swap or skip straight to output
         fys_pkg::ST_SETUP: begin
            if (cnt_ff < fys_pkg::CNT_W'(2) || (!full_mode && k_calc == '0)) begin
               p_in     = '0;
               state_in = fys_pkg::ST_OUT_RD;
            end else begin
               k_in           = k_calc;
               i_in           = full_mode ? fys_pkg::IDX_W'(cnt_ff - fys_pkg::CNT_W'(1)) : '0;
               m_in           = '0;
               rand_cmd.re    = 1'b1;
               rand_cmd.raddr = '0;
               state_in       = fys_pkg::ST_MOD_START;
            end
         end

         // reduce the random byte by the span of this step
         fys_pkg::ST_MOD_START: begin
            div_req.start    = 1'b1;
            div_req.dividend = rand_rdata;
            div_req.divisor  = full_mode ? (fys_pkg::CNT_W'(i_ff) + fys_pkg::CNT_W'(1))
                                         : (cnt_ff - fys_pkg::CNT_W'(i_ff));
            state_in         = fys_pkg::ST_MOD_WAIT;
         end

         // form the partner index and fetch element i
         fys_pkg::ST_MOD_WAIT: begin
            if (div_rsp.done) begin
               j_in = full_mode ? fys_pkg::IDX_W'(div_rsp.remainder)
                                : i_ff + fys_pkg::IDX_W'(div_rsp.remainder);
               elem_cmd.re    = 1'b1;
               elem_cmd.raddr = i_ff;
               state_in       = fys_pkg::ST_RD_J;
            end
         end

         // hold element i and fetch element j
         fys_pkg::ST_RD_J: begin
            vi_in          = elem_rdata;
            elem_cmd.re    = 1'b1;
            elem_cmd.raddr = j_ff;
            state_in       = fys_pkg::ST_WR_I;
         end

         fys_pkg::ST_WR_I: begin
            elem_cmd.we    = 1'b1;
            elem_cmd.waddr = i_ff;
            elem_cmd.wdata = elem_rdata;
            state_in       = fys_pkg::ST_WR_J;
         end

         // finish the swap and advance to the next step
         fys_pkg::ST_WR_J: begin
            elem_cmd.we    = 1'b1;
            elem_cmd.waddr = j_ff;
            elem_cmd.wdata = vi_ff;
            if (last_step) begin
               p_in     = '0;
               state_in = fys_pkg::ST_OUT_RD;
            end else begin
               i_in           = full_mode ? i_ff - fys_pkg::IDX_W'(1)
                                          : i_ff + fys_pkg::IDX_W'(1);
               m_in           = m_ff + fys_pkg::IDX_W'(1);
               rand_cmd.re    = 1'b1;
               rand_cmd.raddr = m_ff + fys_pkg::IDX_W'(1);
               state_in       = fys_pkg::ST_MOD_START;
            end
         end

         fys_pkg::ST_OUT_RD: begin
            elem_cmd.re    = 1'b1;
            elem_cmd.raddr = p_ff;
            state_in       = fys_pkg::ST_OUT_LD;
         end

         // move the word into the output register once it is free
         fys_pkg::ST_OUT_LD: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = elem_rdata;
               rsp_last_in  = ((fys_pkg::CNT_W'(p_ff) + fys_pkg::CNT_W'(1)) == cnt_ff);
               if (rsp_last_in) begin
                  cnt_in   = '0;
                  state_in = fys_pkg::ST_LOAD;
               end else begin
                  p_in     = p_ff + fys_pkg::IDX_W'(1);
                  state_in = fys_pkg::ST_OUT_RD;
               end
            end
         end

         default: begin
            state_in = fys_pkg::ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fys_pkg::ST_LOAD;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // indexes and payload need no reset
   always_ff @(posedge clock) begin
      k_ff        <= k_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      m_ff        <= m_in;
      p_ff        <= p_in;
      vi_ff       <= vi_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTH
   // a swap partner always lies inside the loaded list
   a_j_in_list: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fys_pkg::ST_WR_I) |-> (fys_pkg::CNT_W'(j_ff) < cnt_ff))
      else $error("swap partner outside the loaded list");

   // the last word closes the input side
   a_close_on_last: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tlast) |=> !req_tready)
      else $error("input still open after last word");

   // fill count never passes capacity
   a_cnt_cap: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= fys_pkg::CNT_W'(fys_pkg::MAX_ITEMS))
      else $error("fill count beyond capacity");
`endif

endmodule

[sim/fisher_yates_shuffle_engine_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shuffle engine testbench
// Streams lists of element/random word pairs into the engine under both
// shuffle modes and several partial counts. A scoreboard permutes each list
// on its own and checks every permuted word in order. Sender gaps, receiver
// stalls and two long output hold-offs vary the timing across phases.
// ----------------------------------------------------------------------------
module fisher_yates_shuffle_engine_tb;

   // one permuted word as seen on the result channel
   typedef struct packed {
      logic [7:0] value;
      logic       last;
   } shuffled_word_type;

   // ------------------------------------------------------------------------
   // List model: stores words, permutes on the final one, queues the results
   // ------------------------------------------------------------------------
   class shuffle_scoreboard_type;
      logic [7:0]                  elems [fys_pkg::MAX_ITEMS];
      logic [7:0]                  rnds  [fys_pkg::MAX_ITEMS];
      int unsigned                 loaded;
      logic [fys_pkg::MODE_W-1:0]  mode;
      logic [fys_pkg::PCNT_W-1:0]  pcount;
      shuffled_word_type           expected_words [$];
      int unsigned                 errors;

      function new();
         loaded = 0;
         mode   = fys_pkg::MODE_FULL;
         pcount = '0;
         errors = 0;
      endfunction

      function int unsigned pending();
         return expected_words.size();
      endfunction

      // permute the stored list in place, one swap per random byte
      function void permute_list(int unsigned n);
         int unsigned m;
         int unsigned k;
         int unsigned j;
         logic [7:0]  t;
         m = 0;
         if (n < 2) return;
         if (mode == fys_pkg::MODE_FULL) begin
            for (int unsigned i = n - 1; i > 0; i--) begin
               j = rnds[m] % (i + 1);
               t = elems[i]; elems[i] = elems[j]; elems[j] = t;
               m++;
            end
         end else begin
            k = (pcount > n) ? n : pcount;
            for (int unsigned i = 0; i < k; i++) begin
               j = i + rnds[m] % (n - i);
               t = elems[i]; elems[i] = elems[j]; elems[j] = t;
               m++;
            end
         end
      endfunction

      // store an accepted word; on the final word queue the permuted list
      function void note_word(logic [7:0] value, logic [7:0] rnd, logic last);
         shuffled_word_type w;
         if (loaded < fys_pkg::MAX_ITEMS) begin
            elems[loaded] = value;
            rnds[loaded]  = rnd;
            loaded++;
         end
         if (last) begin
            permute_list(loaded);
            for (int unsigned p = 0; p < loaded; p++) begin
               w.value = elems[p];
               w.last  = (p + 1 == loaded);
               expected_words.push_back(w);
            end
            loaded = 0;
         end
      endfunction

      task report(string msg);
         if (errors < 40) $display("[%0t] mismatch: %s", $realtime, msg);
         errors++;
      endtask

      // compare one accepted result word with the oldest expectation
      task check_word(logic [7:0] value, logic last);
         shuffled_word_type w;
         if (expected_words.size() == 0) begin
            report($sformatf("unexpected word value=%02h last=%0b", value, last));
         end else begin
            w = expected_words.pop_front();
            if (value !== w.value)
               report($sformatf("value %02h, expected %02h", value, w.value));
            if (last !== w.last)
               report($sformatf("last %0b, expected %0b (value %02h)", last, w.last,
                                w.value));
         end
      endtask
   endclass

   // ------------------------------------------------------------------------
   // Signals
   // ------------------------------------------------------------------------
   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [15:0]                req_tdata = '0;   // [7:0] element_value, [15:8] rand_byte
   logic                       req_tlast = 1'b0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [7:0]                 rsp_tdata;        // [7:0] out_value
   logic                       rsp_tlast;
   logic                       csr_psel = 1'b0;
   logic                       csr_penable = 1'b0;
   logic                       csr_pwrite = 1'b0;
   logic [fys_pkg::ADDR_W-1:0] csr_paddr = '0;
   logic [fys_pkg::CSR_W-1:0]  csr_pwdata = '0;
   logic [fys_pkg::CSR_W-1:0]  csr_prdata;
   logic                       csr_pready;

   shuffle_scoreboard_type sb = new();

   int unsigned gap_pct   = 0;
   int unsigned stall_pct = 0;
   logic        hold_req  = 1'b0;
   int unsigned hold_left = 0;

   fisher_yates_shuffle_engine u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // receiver: long hold-off on request, else random stalls
   always @(posedge clock) begin
      if (hold_req) begin
         hold_left = 600;
         hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // check every accepted result word
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_word(rsp_tdata, rsp_tlast);
   end

   // ------------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------------
   // offer one word, with random gaps ahead of it, and note it once taken
   task send_word(logic [7:0] value, logic [7:0] rnd, logic last);
      while ($urandom_range(99) < gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {rnd, value};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      sb.note_word(value, rnd, last);
   endtask

   task send_random_list(int unsigned len);
      for (int unsigned i = 0; i < len; i++)
         send_word(8'($urandom_range(255)), 8'($urandom_range(255)), i + 1 == len);
   endtask

   // setup then access cycle; the register takes the value on the access edge
   task write_csr(logic [fys_pkg::REG_IDX_W-1:0] idx, logic [fys_pkg::CSR_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (idx == fys_pkg::REG_SHUFFLE_MODE) sb.mode = value[fys_pkg::MODE_W-1:0];
      else                                  sb.pcount = value[fys_pkg::PCNT_W-1:0];
   endtask

   // wait for every expected word, then let the sequencer get back to loading
   task drain_lists();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   // one random phase: register setting, idling style, about n_items words
   task run_phase(logic [fys_pkg::MODE_W-1:0] mode, logic [fys_pkg::PCNT_W-1:0] pcnt,
                  int unsigned gap, int unsigned stall, int unsigned n_items,
                  logic overflow, logic pressure);
      int unsigned sent;
      int unsigned len;
      write_csr(fys_pkg::REG_SHUFFLE_MODE, fys_pkg::CSR_W'(mode));
      write_csr(fys_pkg::REG_PARTIAL_COUNT, fys_pkg::CSR_W'(pcnt));
      gap_pct   = gap;
      stall_pct = stall;
      if (pressure) hold_req = 1'b1;
      sent = 0;
      // overflow list first: words beyond capacity are dropped
      if (overflow) begin
         len = $urandom_range(fys_pkg::MAX_ITEMS + 1, fys_pkg::MAX_ITEMS + 4);
         send_random_list(len);
         sent += len;
      end
      while (sent < n_items) begin
         if ($urandom_range(9) == 0) len = $urandom_range(11, fys_pkg::MAX_ITEMS);
         else                        len = $urandom_range(1, 10);
         send_random_list(len);
         sent += len;
      end
      drain_lists();
   endtask

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // full shuffle from reset: single-word lists and short lists
      send_word(8'h00, 8'hFF, 1'b1);
      send_word(8'hFF, 8'h00, 1'b1);
      send_word(8'h11, 8'h00, 1'b0);
      send_word(8'hEE, 8'hFF, 1'b1);
      send_word(8'h01, 8'h01, 1'b0);
      send_word(8'h02, 8'h02, 1'b0);
      send_word(8'h03, 8'h80, 1'b1);
      drain_lists();

      // partial shuffle, count above the list length
      write_csr(fys_pkg::REG_SHUFFLE_MODE, fys_pkg::CSR_W'(fys_pkg::MODE_PARTIAL));
      write_csr(fys_pkg::REG_PARTIAL_COUNT, fys_pkg::CSR_W'(64));
      send_word(8'h10, 8'hFF, 1'b0);
      send_word(8'h20, 8'h03, 1'b0);
      send_word(8'h30, 8'h02, 1'b0);
      send_word(8'h40, 8'h01, 1'b1);
      drain_lists();

      // partial shuffle with no steps leaves the list unchanged
      write_csr(fys_pkg::REG_PARTIAL_COUNT, fys_pkg::CSR_W'(0));
      send_word(8'hA5, 8'hFF, 1'b0);
      send_word(8'h5A, 8'hFF, 1'b0);
      send_word(8'hC3, 8'hFF, 1'b1);
      drain_lists();

      write_csr(fys_pkg::REG_PARTIAL_COUNT, fys_pkg::CSR_W'(2));
      send_word(8'h01, 8'hFE, 1'b0);
      send_word(8'h02, 8'h7F, 1'b0);
      send_word(8'h04, 8'h00, 1'b0);
      send_word(8'h08, 8'h55, 1'b0);
      send_word(8'h80, 8'hAA, 1'b1);
      drain_lists();

      // random phases
      run_phase(fys_pkg::MODE_FULL,    fys_pkg::PCNT_W'(0),  0,  0,  45, 1'b1, 1'b0);
      run_phase(fys_pkg::MODE_PARTIAL, fys_pkg::PCNT_W'(64), 50, 0,  45, 1'b0, 1'b0);
      run_phase(fys_pkg::MODE_PARTIAL, fys_pkg::PCNT_W'($urandom_range(1, 8)),
                0, 50, 45, 1'b1, 1'b0);
      run_phase(fys_pkg::MODE_FULL,    fys_pkg::PCNT_W'(0),  31, 31, 45, 1'b0, 1'b1);
      run_phase(fys_pkg::MODE_PARTIAL, fys_pkg::PCNT_W'(0),  0,  0,  20, 1'b0, 1'b0);
      run_phase(fys_pkg::MODE_PARTIAL, fys_pkg::PCNT_W'($urandom_range(9, 40)),
                0, 0, 30, 1'b0, 1'b1);

      repeat (40) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
